// ===== design/btah_pkg.sv =====
// ----------------------------------------------------------------------------
// btah_pkg: shared types and constants of the budget tier allocator
// Item structs, configuration struct, tier codes, scale factors, sizes.
// ----------------------------------------------------------------------------
package btah_pkg;

	// sizes
	localparam int SLOTS       = 64;
	localparam int SLOT_AW     = $clog2(SLOTS);
	localparam int DUP_ENTRIES = 16;
	localparam int DUP_AW      = (DUP_ENTRIES > 1) ? $clog2(DUP_ENTRIES) : 1;
	localparam int MQ_DEPTH    = 4;
	localparam int MQ_AW       = $clog2(MQ_DEPTH);
	localparam int USED_CAP_W  = 14;
	localparam int USED_RATE_W = 17;
	localparam int SLOT_RAM_W  = 36;

	// tier codes
	localparam logic [1:0] TIER_FULL    = 2'd0;
	localparam logic [1:0] TIER_REDUCED = 2'd1;
	localparam logic [1:0] TIER_MINIMAL = 2'd2;
	localparam logic [1:0] TIER_OFF     = 2'd3;

	// Q0.16 scale factors, rounded up
	localparam logic [14:0] SCALE_RED_CAP  = 15'd26215;
	localparam logic [14:0] SCALE_MIN_CAP  = 15'd7865;
	localparam logic [14:0] SCALE_RED_RATE = 15'd22938;
	localparam logic [14:0] SCALE_MIN_RATE = 15'd5243;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_BUDGET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_RATE_BUDGET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FULL_DUPS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEMOTE_DELAY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PROMOTE_DELAY    = 3'd4;

	// reset values
	localparam logic [12:0] RST_CAPACITY_BUDGET  = 13'd480;
	localparam logic [15:0] RST_EMIT_RATE_BUDGET = 16'd5760;
	localparam logic [2:0]  RST_MAX_FULL_DUPS    = 3'd3;
	localparam logic [15:0] RST_DEMOTE_DELAY     = 16'd250;
	localparam logic [15:0] RST_PROMOTE_DELAY    = 16'd1000;

	typedef struct packed {
		logic        frame_start;
		logic        new_record;
		logic [5:0]  slot;
		logic [15:0] npc_id;
		logic [31:0] effect_hash;
		logic [11:0] configured_capacity;
		logic [15:0] emit_rate;
		logic [7:0]  emitter_count;
		logic        visible;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [5:0] out_slot;
		logic [1:0] desired_tier;
		logic [1:0] applied_tier;
		logic       tier_changed;
	} res_t;

	typedef struct packed {
		logic [12:0] capacity_budget;
		logic [15:0] emit_rate_budget;
		logic [2:0]  max_full_duplicates;
		logic [15:0] demote_delay;
		logic [15:0] promote_delay;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [5:0]  slot;
		logic        new_record;
		logic        visible;
		logic [1:0]  want;
		logic [31:0] now;
	} mid_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

endpackage

// ===== design/btah_ram.sv =====
// ----------------------------------------------------------------------------
// btah_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module btah_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/btah_front.sv =====
// ----------------------------------------------------------------------------
// btah_front: cost stage, tier pick and hand-off queue
// Stage 1 registers the item with its tier costs and signature. Stage 2
// checks the budgets and duplicate table, charges the pick, and pushes the
// classified item into a short queue toward the hysteresis back end.
// ----------------------------------------------------------------------------
module btah_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  btah_pkg::req_t  req,
	input  btah_pkg::cfg_t  cfg,
	input  logic            mq_pop,
	output logic            mq_empty,
	output btah_pkg::mid_t  mq_head
);
	import btah_pkg::*;

	// stage 1 registers
	logic        v_s1;
	logic        fs_s1;
	logic        nr_s1;
	logic [5:0]  slot_s1;
	logic        vis_s1;
	logic [31:0] now_s1;
	logic [63:0] sig_s1;
	logic [11:0] cc0_s1;
	logic [15:0] rc0_s1;
	logic [10:0] cc1_s1;
	logic [15:0] rc1_s1;
	logic [10:0] cc2_s1;
	logic [15:0] rc2_s1;

	// cost computation
	logic [27:0] red_cap_p;
	logic [27:0] min_cap_p;
	logic [31:0] red_rate_p;
	logic [31:0] min_rate_p;
	logic [10:0] em8, em2, em6, red_cap, min_lo, min_cap;

	always_comb begin
		red_cap_p  = 28'(req.configured_capacity) * 28'(SCALE_RED_CAP);
		min_cap_p  = 28'(req.configured_capacity) * 28'(SCALE_MIN_CAP);
		red_rate_p = 32'(req.emit_rate) * 32'(SCALE_RED_RATE);
		min_rate_p = 32'(req.emit_rate) * 32'(SCALE_MIN_RATE);
		em8 = {req.emitter_count, 3'b000};
		em2 = {2'b00, req.emitter_count, 1'b0};
		em6 = 11'({req.emitter_count, 2'b00}) + em2;
		red_cap = (em8 > red_cap_p[26:16]) ? em8 : red_cap_p[26:16];
		min_lo  = (em2 > min_cap_p[26:16]) ? em2 : min_cap_p[26:16];
		min_cap = (em6 < min_lo) ? em6 : min_lo;
	end

	// queue state
	mid_t             mq_q [MQ_DEPTH];
	logic [MQ_AW-1:0] mq_wp_q, mq_rp_q;
	logic [MQ_AW:0]   mq_cnt_q;
	logic             mq_full;
	logic             commit;
	logic             take;

	assign mq_full  = (mq_cnt_q == (MQ_AW+1)'(MQ_DEPTH));
	assign mq_empty = (mq_cnt_q == '0);
	assign mq_head  = mq_q[mq_rp_q];
	assign commit   = v_s1 && !mq_full;
	assign full     = v_s1 && mq_full;
	assign take     = push && !full;

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (commit) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fs_s1   <= req.frame_start;
			nr_s1   <= req.new_record;
			slot_s1 <= req.slot;
			vis_s1  <= req.visible;
			now_s1  <= req.now;
			sig_s1  <= {req.npc_id, 16'h0000, req.effect_hash};
			cc0_s1  <= req.configured_capacity;
			rc0_s1  <= req.emit_rate;
			cc1_s1  <= red_cap;
			rc1_s1  <= red_rate_p[31:16];
			cc2_s1  <= min_cap;
			rc2_s1  <= min_rate_p[31:16];
		end
	end

	// frame totals and duplicate table
	logic [USED_CAP_W-1:0]  used_cap_q;
	logic [USED_RATE_W-1:0] used_rate_q;
	logic                   dup_v_q   [DUP_ENTRIES];
	logic [2:0]             dup_cnt_q [DUP_ENTRIES];
	logic [63:0]            dup_sig_q [DUP_ENTRIES];

	logic [USED_CAP_W-1:0]  ucap;
	logic [USED_RATE_W-1:0] urate;
	logic                   dv [DUP_ENTRIES];
	logic [2:0]             dc [DUP_ENTRIES];
	logic                   hit_f, fre_f;
	logic [DUP_AW-1:0]      hit_i, fre_i;
	logic                   full_ok, fit0, fit1, fit2;
	logic [1:0]             want;
	logic [11:0]            cc_chg;
	logic [15:0]            rc_chg;

	// stage 2: tier pick
	always_comb begin
		ucap  = fs_s1 ? '0 : used_cap_q;
		urate = fs_s1 ? '0 : used_rate_q;
		hit_f = 1'b0;
		fre_f = 1'b0;
		hit_i = '0;
		fre_i = '0;
		for (int i = 0; i < DUP_ENTRIES; i++) begin
			dv[i] = fs_s1 ? 1'b0 : dup_v_q[i];
			dc[i] = fs_s1 ? 3'd0 : dup_cnt_q[i];
		end
		// first matching entry, first free entry
		for (int i = 0; i < DUP_ENTRIES; i++) begin
			if (dv[i]) begin
				if (!hit_f && dup_sig_q[i] == sig_s1) begin
					hit_f = 1'b1;
					hit_i = DUP_AW'(i);
				end
			end else if (!fre_f) begin
				fre_f = 1'b1;
				fre_i = DUP_AW'(i);
			end
		end
		full_ok = (hit_f && dc[hit_i] < cfg.max_full_duplicates) ||
			(!hit_f && fre_f && cfg.max_full_duplicates != 3'd0);
		fit0 = (15'(ucap) + 15'(cc0_s1) <= 15'(cfg.capacity_budget)) &&
			(18'(urate) + 18'(rc0_s1) <= 18'(cfg.emit_rate_budget));
		fit1 = (15'(ucap) + 15'(cc1_s1) <= 15'(cfg.capacity_budget)) &&
			(18'(urate) + 18'(rc1_s1) <= 18'(cfg.emit_rate_budget));
		fit2 = (15'(ucap) + 15'(cc2_s1) <= 15'(cfg.capacity_budget)) &&
			(18'(urate) + 18'(rc2_s1) <= 18'(cfg.emit_rate_budget));
		priority if (!vis_s1) begin
			want   = TIER_OFF;
			cc_chg = '0;
			rc_chg = '0;
		end else if (full_ok && fit0) begin
			want   = TIER_FULL;
			cc_chg = cc0_s1;
			rc_chg = rc0_s1;
		end else if (fit1) begin
			want   = TIER_REDUCED;
			cc_chg = 12'(cc1_s1);
			rc_chg = rc1_s1;
		end else if (fit2) begin
			want   = TIER_MINIMAL;
			cc_chg = 12'(cc2_s1);
			rc_chg = rc2_s1;
		end else begin
			want   = TIER_OFF;
			cc_chg = '0;
			rc_chg = '0;
		end
	end

	// totals and duplicate control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_cap_q  <= '0;
			used_rate_q <= '0;
			for (int i = 0; i < DUP_ENTRIES; i++) begin
				dup_v_q[i]   <= 1'b0;
				dup_cnt_q[i] <= 3'd0;
			end
		end else if (commit) begin
			used_cap_q  <= ucap + USED_CAP_W'(cc_chg);
			used_rate_q <= urate + USED_RATE_W'(rc_chg);
			for (int i = 0; i < DUP_ENTRIES; i++) begin
				dup_v_q[i]   <= dv[i];
				dup_cnt_q[i] <= dc[i];
			end
			if (want == TIER_FULL && vis_s1) begin
				if (hit_f) begin
					dup_cnt_q[hit_i] <= dc[hit_i] + 3'd1;
				end else begin
					dup_v_q[fre_i]   <= 1'b1;
					dup_cnt_q[fre_i] <= 3'd1;
				end
			end
		end
	end

	// signature store, written on a new full grant
	always_ff @(posedge clk) begin
		if (commit && want == TIER_FULL && vis_s1 && !hit_f) begin
			dup_sig_q[fre_i] <= sig_s1;
		end
	end

	// hand-off queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mq_wp_q  <= '0;
			mq_rp_q  <= '0;
			mq_cnt_q <= '0;
		end else begin
			if (commit) begin
				mq_wp_q <= mq_wp_q + MQ_AW'(1);
			end
			if (mq_pop) begin
				mq_rp_q <= mq_rp_q + MQ_AW'(1);
			end
			if (commit && !mq_pop) begin
				mq_cnt_q <= mq_cnt_q + (MQ_AW+1)'(1);
			end else if (!commit && mq_pop) begin
				mq_cnt_q <= mq_cnt_q - (MQ_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			mq_q[mq_wp_q] <= '{slot: slot_s1, new_record: nr_s1, visible: vis_s1,
				want: want, now: now_s1};
		end
	end

endmodule

// ===== design/btah_back.sv =====
// ----------------------------------------------------------------------------
// btah_back: per-slot hysteresis and result queue
// Reads the slot record from RAM, decides the applied tier, writes the
// record back and queues the result item; no new item is taken until then.
// ----------------------------------------------------------------------------
module btah_back (
	input  logic            clk,
	input  logic            arst_n,
	input  btah_pkg::cfg_t  cfg,
	input  logic            mq_empty,
	input  btah_pkg::mid_t  mq_head,
	output logic            mq_pop,
	output logic            empty,
	input  logic            pop,
	output btah_pkg::res_t  res
);
	import btah_pkg::*;

	bk_state_t             state_q, state_d;
	mid_t                  item_q;
	logic [SLOTS-1:0]      valid_q;
	logic                  rd_en, wr_en, push_out;
	logic [SLOT_RAM_W-1:0] rdata, wdata;
	logic [SLOT_AW-1:0]    idx;

	// output queue
	res_t       oq_q [2];
	logic       owp_q, orp_q;
	logic [1:0] oc_q;

	assign idx = item_q.slot[SLOT_AW-1:0];

	btah_ram #(
		.WIDTH(SLOT_RAM_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (mq_head.slot[SLOT_AW-1:0]),
		.rdata (rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mq_pop   = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		push_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!mq_empty && oc_q != 2'd2) begin
					mq_pop  = 1'b1;
					rd_en   = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				wr_en    = 1'b1;
				push_out = 1'b1;
				state_d  = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mq_pop) begin
			item_q <= mq_head;
		end
	end

	// hysteresis decision
	logic [1:0]  cur_app, cur_des, new_app, new_des;
	logic [31:0] cur_t, new_t, elapsed, delay;
	logic        changed;

	always_comb begin
		if (!valid_q[idx] || item_q.new_record) begin
			cur_app = TIER_FULL;
			cur_des = TIER_FULL;
			cur_t   = '0;
		end else begin
			cur_app = rdata[35:34];
			cur_des = rdata[33:32];
			cur_t   = rdata[31:0];
		end
		elapsed = item_q.now - cur_t;
		delay   = (item_q.want > cur_app) ? 32'(cfg.demote_delay) : 32'(cfg.promote_delay);
		new_app = cur_app;
		new_des = cur_des;
		new_t   = cur_t;
		changed = 1'b0;
		priority if (cur_app == item_q.want) begin
			new_des = item_q.want;
			new_t   = '0;
		end else if (!item_q.visible && item_q.want == TIER_OFF) begin
			new_app = TIER_OFF;
			new_des = TIER_OFF;
			new_t   = '0;
			changed = 1'b1;
		end else if (cur_des != item_q.want) begin
			new_des = item_q.want;
			new_t   = item_q.now;
		end else if (elapsed >= delay) begin
			new_app = item_q.want;
			new_t   = '0;
			changed = 1'b1;
		end else begin
			// still waiting out the delay
			new_t   = cur_t;
		end
		wdata = {new_app, new_des, new_t};
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[idx] <= 1'b1;
		end
	end

	// result queue
	assign empty = (oc_q == 2'd0);
	assign res   = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= 1'b0;
			orp_q <= 1'b0;
			oc_q  <= 2'd0;
		end else begin
			if (push_out) begin
				owp_q <= ~owp_q;
			end
			if (pop && !empty) begin
				orp_q <= ~orp_q;
			end
			if (push_out && !(pop && !empty)) begin
				oc_q <= oc_q + 2'd1;
			end else if (!push_out && pop && !empty) begin
				oc_q <= oc_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			oq_q[owp_q] <= '{out_slot: item_q.slot, desired_tier: item_q.want,
				applied_tier: new_app, tier_changed: changed};
		end
	end

endmodule

// ===== design/budget_tier_allocator_hysteresis_top.sv =====
// Throughput: the back end takes no new item until the slot RAM read and
// write-back of the last one are done; the front end takes one item per
// cycle while its hand-off queue has room.
// Reset: arst_n clears totals, duplicate table, slot records, queues and loads
// the default budgets; no clearing pass is needed.
// ----------------------------------------------------------------------------
// budget_tier_allocator_hysteresis_top: effect budget tier allocator
// Configuration registers, front end (costs and tier pick) and back end
// (per-slot hysteresis), joined by a short queue.
// ----------------------------------------------------------------------------
module budget_tier_allocator_hysteresis_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  btah_pkg::req_t                   req,
	output logic                             empty,
	input  logic                             pop,
	output btah_pkg::res_t                   res,
	input  logic                             wr_en,
	input  logic [btah_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [btah_pkg::CFG_DAT_W-1:0]   wr_data
);
	import btah_pkg::*;

	cfg_t cfg_q;
	logic mq_pop, mq_empty;
	mid_t mq_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity_budget     <= RST_CAPACITY_BUDGET;
			cfg_q.emit_rate_budget    <= RST_EMIT_RATE_BUDGET;
			cfg_q.max_full_duplicates <= RST_MAX_FULL_DUPS;
			cfg_q.demote_delay        <= RST_DEMOTE_DELAY;
			cfg_q.promote_delay       <= RST_PROMOTE_DELAY;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CAPACITY_BUDGET:  cfg_q.capacity_budget     <= wr_data[12:0];
				REG_EMIT_RATE_BUDGET: cfg_q.emit_rate_budget    <= wr_data;
				REG_MAX_FULL_DUPS:    cfg_q.max_full_duplicates <= wr_data[2:0];
				REG_DEMOTE_DELAY:     cfg_q.demote_delay        <= wr_data;
				REG_PROMOTE_DELAY:    cfg_q.promote_delay       <= wr_data;
				default: ;
			endcase
		end
	end

	btah_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.cfg      (cfg_q),
		.mq_pop   (mq_pop),
		.mq_empty (mq_empty),
		.mq_head  (mq_head)
	);

	btah_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.mq_empty (mq_empty),
		.mq_head  (mq_head),
		.mq_pop   (mq_pop),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the budget tier allocator with hysteresis
// Drives requests through the push/full port, pops results at random, and
// compares every result with a behavioral tier allocator kept in a class.
// ----------------------------------------------------------------------------
module tb;
	import btah_pkg::*;

	// behavioral allocator and queue of expected results
	class tier_scoreboard;
		logic [12:0] cap_budget;
		logic [15:0] rate_budget;
		logic [2:0]  dup_limit;
		logic [15:0] demote_ms;
		logic [15:0] promote_ms;
		int unsigned used_cap;
		int unsigned used_rate;
		logic [63:0] sig_tab [DUP_ENTRIES];
		logic [2:0]  sig_cnt [DUP_ENTRIES];
		bit          sig_val [DUP_ENTRIES];
		logic [1:0]  applied [SLOTS];
		logic [1:0]  desired [SLOTS];
		logic [31:0] req_ms [SLOTS];
		res_t        pending [$];
		int          errors;

		function new();
			cap_budget  = RST_CAPACITY_BUDGET;
			rate_budget = RST_EMIT_RATE_BUDGET;
			dup_limit   = RST_MAX_FULL_DUPS;
			demote_ms   = RST_DEMOTE_DELAY;
			promote_ms  = RST_PROMOTE_DELAY;
			used_cap = 0;
			used_rate = 0;
			errors = 0;
			foreach (sig_val[i]) begin
				sig_val[i] = 1'b0;
				sig_cnt[i] = 3'd0;
			end
			foreach (applied[i]) begin
				applied[i] = TIER_FULL;
				desired[i] = TIER_FULL;
				req_ms[i] = 32'd0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_CAPACITY_BUDGET:  cap_budget  = val[12:0];
				REG_EMIT_RATE_BUDGET: rate_budget = val;
				REG_MAX_FULL_DUPS:    dup_limit   = val[2:0];
				REG_DEMOTE_DELAY:     demote_ms   = val;
				REG_PROMOTE_DELAY:    promote_ms  = val;
				default: ;
			endcase
		endfunction

		function void cost_of(logic [1:0] tier, req_t r, output int unsigned cc,
				output int unsigned rc);
			int unsigned sc;
			int unsigned em;
			em = 32'(r.emitter_count);
			case (tier)
				TIER_FULL: begin
					cc = 32'(r.configured_capacity);
					rc = 32'(r.emit_rate);
				end
				TIER_REDUCED: begin
					sc = (32'(r.configured_capacity) * 32'(SCALE_RED_CAP)) >> 16;
					cc = (8 * em > sc) ? 8 * em : sc;
					rc = (32'(r.emit_rate) * 32'(SCALE_RED_RATE)) >> 16;
				end
				TIER_MINIMAL: begin
					sc = (32'(r.configured_capacity) * 32'(SCALE_MIN_CAP)) >> 16;
					if (2 * em > sc) sc = 2 * em;
					cc = (6 * em < sc) ? 6 * em : sc;
					rc = (32'(r.emit_rate) * 32'(SCALE_MIN_RATE)) >> 16;
				end
				default: begin
					cc = 0;
					rc = 0;
				end
			endcase
		endfunction

		function bit fits(int unsigned cc, int unsigned rc);
			return used_cap + cc <= cap_budget && used_rate + rc <= rate_budget;
		endfunction

		function logic [1:0] pick(req_t r);
			logic [63:0] sig;
			int hit, fre;
			int unsigned cc, rc;
			if (!r.visible) return TIER_OFF;
			sig = {r.npc_id, 48'd0} ^ {32'd0, r.effect_hash};
			hit = -1;
			fre = -1;
			for (int i = 0; i < DUP_ENTRIES; i++) begin
				if (sig_val[i]) begin
					if (hit < 0 && sig_tab[i] == sig) hit = i;
				end else if (fre < 0) fre = i;
			end
			if ((hit >= 0 && sig_cnt[hit] < dup_limit) ||
					(hit < 0 && fre >= 0 && dup_limit > 0)) begin
				cost_of(TIER_FULL, r, cc, rc);
				if (fits(cc, rc)) begin
					used_cap += cc;
					used_rate += rc;
					if (hit >= 0) sig_cnt[hit] = sig_cnt[hit] + 3'd1;
					else begin
						sig_val[fre] = 1'b1;
						sig_tab[fre] = sig;
						sig_cnt[fre] = 3'd1;
					end
					return TIER_FULL;
				end
			end
			for (int t = TIER_REDUCED; t <= TIER_MINIMAL; t++) begin
				cost_of(t[1:0], r, cc, rc);
				if (fits(cc, rc)) begin
					used_cap += cc;
					used_rate += rc;
					return t[1:0];
				end
			end
			return TIER_OFF;
		endfunction

		// note an accepted request and queue its result
		function void note_request(req_t r);
			int s;
			logic [1:0] want;
			logic [31:0] dly;
			res_t e;
			s = r.slot % SLOTS;
			e.tier_changed = 1'b0;
			if (r.frame_start) begin
				used_cap = 0;
				used_rate = 0;
				foreach (sig_val[i]) begin
					sig_val[i] = 1'b0;
					sig_cnt[i] = 3'd0;
				end
			end
			if (r.new_record) begin
				applied[s] = TIER_FULL;
				desired[s] = TIER_FULL;
				req_ms[s] = 32'd0;
			end
			want = pick(r);
			if (applied[s] == want) begin
				desired[s] = want;
				req_ms[s] = 32'd0;
			end else if (!r.visible && want == TIER_OFF) begin
				applied[s] = TIER_OFF;
				desired[s] = TIER_OFF;
				req_ms[s] = 32'd0;
				e.tier_changed = 1'b1;
			end else if (desired[s] != want) begin
				desired[s] = want;
				req_ms[s] = r.now;
			end else begin
				dly = (want > applied[s]) ? 32'(demote_ms) : 32'(promote_ms);
				if (r.now - req_ms[s] >= dly) begin
					applied[s] = want;
					req_ms[s] = 32'd0;
					e.tier_changed = 1'b1;
				end
			end
			e.out_slot = r.slot;
			e.desired_tier = want;
			e.applied_tier = applied[s];
			pending.insert(pending.size(), e);
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10) $display("result mismatch: expected %p, got %p", exp, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	req_t req = '0;
	logic empty;
	logic pop = 0;
	res_t res;
	logic wr_en = 0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DAT_W-1:0] wr_data = '0;

	tier_scoreboard sb = new();
	bit idle_free = 0;
	bit hold_off = 0;
	logic [31:0] clock_ms = 0;

	always #1 clk = ~clk;

	budget_tier_allocator_hysteresis_top i_dut (.*);

	// result side: random pop, long hold-off on request
	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_result(res);
		if (hold_off) pop <= 0;
		else pop <= idle_free ? 1'b1 : ($urandom_range(99) >= 13);
	end

	// input side: note accepted requests
	always @(posedge clk) begin
		if (arst_n && push && !full) sb.note_request(req);
	end

	// push stays high after acceptance; the caller drops it when done
	task automatic send(req_t r);
		while (!idle_free && $urandom_range(99) < 13) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// wr_en stays high after the write; the caller drops it when done
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic req_t rand_req(bit fs, int sig_pool);
		req_t r;
		r.frame_start = fs;
		r.new_record = ($urandom_range(19) == 0);
		r.slot = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(7));
		r.npc_id = sig_pool > 0 ? 16'($urandom_range(sig_pool)) : 16'($urandom);
		r.effect_hash = sig_pool > 0 ? $urandom_range(sig_pool) : $urandom;
		case ($urandom_range(3))
			0: r.configured_capacity = 12'($urandom);
			default: r.configured_capacity = 12'($urandom_range(200));
		endcase
		r.emit_rate = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
		r.emitter_count = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20));
		r.visible = $urandom_range(9) != 0;
		clock_ms += $urandom_range(3) == 0 ? $urandom : $urandom_range(400);
		r.now = clock_ms;
		return r;
	endfunction

	// run limit
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus
	initial begin
		req_t r;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, duplicates, hysteresis, invisible, table full
		r = '0;
		r.frame_start = 1;
		r.visible = 1;
		r.configured_capacity = 12'hfff;
		r.emit_rate = 16'hffff;
		r.emitter_count = 8'hff;
		r.slot = 6'h3f;
		r.npc_id = 16'hffff;
		r.effect_hash = 32'hffffffff;
		r.now = 32'hffffffff;
		send(r);
		r = '0;
		r.visible = 1;
		r.configured_capacity = 12'd10;
		r.emit_rate = 16'd16;
		r.emitter_count = 8'd1;
		for (int i = 0; i < 5; i++) send(r);
		for (int i = 0; i < 17; i++) begin
			r.effect_hash = 32'(i + 100);
			r.slot = 6'(i);
			r.now = 32'(i * 300);
			send(r);
		end
		r.visible = 0;
		r.new_record = 1;
		send(r);
		push <= 0;
		drain();

		// several configuration settings, random part in each
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_CAPACITY_BUDGET, 16'h1fff);
					write_reg(REG_EMIT_RATE_BUDGET, 16'hffff);
					write_reg(REG_MAX_FULL_DUPS, 16'd7);
					write_reg(REG_DEMOTE_DELAY, 16'd0);
					write_reg(REG_PROMOTE_DELAY, 16'd0);
				end
				1: begin
					write_reg(REG_CAPACITY_BUDGET, 16'd0);
					write_reg(REG_EMIT_RATE_BUDGET, 16'd0);
					write_reg(REG_MAX_FULL_DUPS, 16'd0);
					write_reg(REG_DEMOTE_DELAY, 16'hffff);
					write_reg(REG_PROMOTE_DELAY, 16'hffff);
				end
				default: begin
					write_reg(REG_CAPACITY_BUDGET, 16'($urandom_range(1500)));
					write_reg(REG_EMIT_RATE_BUDGET, 16'($urandom_range(20000)));
					write_reg(REG_MAX_FULL_DUPS, 16'($urandom_range(7)));
					write_reg(REG_DEMOTE_DELAY, 16'($urandom_range(600)));
					write_reg(REG_PROMOTE_DELAY, 16'($urandom_range(1500)));
					write_reg(3'd7, 16'($urandom));
				end
			endcase
			wr_en <= 0;
			idle_free = (ph == 3);
			for (int i = 0; i < 180; i++)
				send(rand_req($urandom_range(11) == 0, ph == 4 ? 0 : 5));
			push <= 0;
			drain();
		end

		// back-pressure: receiver holds off while sender keeps pushing
		hold_off = 1;
		fork
			begin
				for (int i = 0; i < 30; i++) send(rand_req(i == 0, 5));
				push <= 0;
			end
			begin
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
		join
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
